// ===== src/mpva_pkg.sv =====
package mpva_pkg;

  localparam int VOICE_COUNT   = 32;
  localparam int CHANNEL_COUNT = 16;
  localparam int SAMPLE_RATE   = 37500;
  localparam int SLOT_W        = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int CNT_W         = SLOT_W + 1;

  localparam logic [3:0]  DRUM_CHANNEL  = 4'd9;
  localparam logic [15:0] RELEASE_TICKS = 16'(SAMPLE_RATE / 8);
  localparam logic [15:0] DECAY_POS     = 16'(SAMPLE_RATE / 2);
  localparam logic [15:0] DRUM_TIMEOUT  = 16'(SAMPLE_RATE);

  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] SYSEX_END   = 8'hF7;
  localparam logic [6:0] CC_VOLUME   = 7'h07;
  localparam logic [6:0] CC_SUSTAIN  = 7'h40;
  localparam logic [6:0] CC_ALL_OFF  = 7'h78;
  localparam logic [6:0] CC_NOTES_OFF = 7'h7B;
  localparam logic [6:0] CC_RESET    = 7'h79;

  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_CTRL     = 4'hB;
  localparam logic [3:0] ST_PROGRAM  = 4'hC;

  localparam logic [1:0] REQ_MIDI    = 2'd0;
  localparam logic [1:0] REQ_TICK    = 2'd1;
  localparam logic [1:0] REQ_ALL_OFF = 2'd2;

  localparam logic [1:0] MSG_LEN [8] = '{2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd3, 2'd1};

  typedef struct packed {
    logic [3:0]  chan;
    logic [6:0]  note;
    logic [6:0]  level;
    logic [6:0]  base;
    logic [15:0] pos;
    logic [15:0] rel;
  } voice_t;

  localparam int VOICE_W = $bits(voice_t);

  typedef struct packed {
    logic [4:0] slot;
    logic       active;
    logic [3:0] chan;
    logic [6:0] note;
    logic [6:0] level;
  } res_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_NOTE_ON, OP_NOTE_OFF, OP_VOLUME,
    OP_SUSTAIN, OP_ALL_OFF, OP_PROGRAM, OP_TICK
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE, S_NOTE_ON, S_WALK, S_FLUSH
  } state_e;

endpackage

// ===== src/midi_parser_voice_allocator.sv =====
// A byte that completes no message is taken with busy left low; a note-on keeps busy
// high through S_NOTE_ON and S_FLUSH, and its result is registered onto the ports.
// A voice walk (tick, note-off, channel controllers, program change, all-off) keeps busy
// high while it reads the voices (a note-on with no free voice first passes S_NOTE_ON);
// a note-off walk ends at the first
// match. Results come one per cycle at most; the receiver cannot stall them.
// Reset (rst_ni low, asynchronous) clears all voices, masks, volumes and parser.
module midi_parser_voice_allocator
  import mpva_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] req_type_i,
  input  logic [7:0] midi_byte_i,
  output logic       result_strobe_o,
  output logic [4:0] voice_slot_o,
  output logic       voice_active_o,
  output logic [3:0] voice_channel_o,
  output logic [6:0] voice_note_o,
  output logic [6:0] voice_level_o,
  output logic       last_change_o
);

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic [3:0]  ch_q, ch_d;
  logic [6:0]  d1_q, d1_d, d2_q, d2_d;
  logic [23:0] word_q, word_d;
  logic [2:0]  pos_q, pos_d;
  logic [1:0]  len_q, len_d;
  logic        sysex_q, sysex_d;
  logic [CHANNEL_COUNT-1:0] sustain_q, sustain_d;
  logic [6:0]  vol_q [CHANNEL_COUNT];
  logic [6:0]  vol_d [CHANNEL_COUNT];
  logic [VOICE_COUNT-1:0] mask_q, mask_d, vld_q, vld_d;
  logic [CNT_W-1:0]  rd_cnt_q, rd_cnt_d;
  logic              p_vld_q, p_vld_d, hit_q, hit_d;
  logic [SLOT_W-1:0] p_idx_q, p_idx_d;
  logic              pend_vld_q, pend_vld_d;
  res_t              pend_q, pend_d, out_q, out_d;
  logic              out_stb_q, out_stb_d, out_last_q, out_last_d;

  logic accept;
  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // parser, evaluated on the incoming byte
  logic        is_stat, apply;
  logic [1:0]  len_n;
  logic [2:0]  pos_n;
  logic [23:0] word_n;
  logic        sx_n;
  logic [3:0]  mch;
  logic [6:0]  md1, md2;

  always_comb begin
    is_stat = midi_byte_i[7] && !(midi_byte_i == SYSEX_END && sysex_q);
    len_n   = len_q;
    pos_n   = pos_q;
    word_n  = word_q;
    sx_n    = sysex_q;
    apply   = 1'b0;
    if (is_stat) begin
      len_n  = MSG_LEN[midi_byte_i[6:4]];
      pos_n  = 3'd0;
      word_n = 24'd0;
      if (midi_byte_i == SYSEX_START) begin
        sx_n = 1'b1;
      end
    end
    if (sx_n) begin
      if (midi_byte_i == SYSEX_END) begin
        sx_n = 1'b0;
      end
    end else if (len_n != 2'd0) begin
      if (pos_n < 3'd3) begin
        word_n = word_n | (24'(midi_byte_i) << {pos_n[1:0], 3'b000});
      end
      if (pos_n < 3'd4) begin
        pos_n = pos_n + 3'd1;
      end
      if (pos_n == {1'b0, len_n}) begin
        apply = 1'b1;
      end
    end
    mch = word_n[3:0];
    md1 = word_n[14:8];
    md2 = word_n[22:16];
  end

  // lowest free voice
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
      if (!mask_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  logic [13:0] on_prod;
  logic [6:0]  on_vol, on_level;
  assign on_vol   = vol_q[ch_q];
  assign on_prod  = 14'(on_vol) * 14'(d2_q);
  assign on_level = (on_vol == 7'd0) ? d2_q : on_prod[13:7];

  // voice RAM
  logic              ram_we, ram_re;
  logic [SLOT_W-1:0] ram_waddr;
  voice_t            ram_wdata, ram_rdata, ent;

  mpva_ram #(
    .WIDTH(VOICE_W),
    .DEPTH(VOICE_COUNT)
  ) u_voice_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(rd_cnt_q[SLOT_W-1:0]),
    .rdata_o(ram_rdata)
  );

  // never-written entries read as zero
  assign ent = vld_q[p_idx_q] ? ram_rdata : '0;

  // per-voice processing stage
  logic       pr_act, pr_wr, pr_emit, pr_stop, pr_hit, pr_live;
  voice_t     pr_ent;
  logic [13:0] vol_prod;
  assign vol_prod = 14'(d2_q) * 14'(ent.base);
  assign pr_live  = (state_q == S_WALK) && p_vld_q && !hit_q;

  always_comb begin
    pr_act  = mask_q[p_idx_q];
    pr_wr   = 1'b0;
    pr_emit = 1'b0;
    pr_stop = 1'b0;
    pr_hit  = 1'b0;
    pr_ent  = ent;
    case (op_q)
      OP_NOTE_OFF: begin
        if (pr_act && ent.chan == ch_q && ent.note == d1_q) begin
          pr_hit = 1'b1;
          if (ch_q == DRUM_CHANNEL) begin
            pr_stop = 1'b1;
          end else begin
            pr_ent.level = ent.level >> 1;
            pr_ent.rel   = ent.pos + RELEASE_TICKS;
            pr_wr        = 1'b1;
            pr_emit      = 1'b1;
          end
        end
      end
      OP_VOLUME: begin
        if (ent.chan == ch_q) begin
          pr_ent.level = vol_prod[13:7];
          pr_wr        = 1'b1;
          pr_emit      = pr_act;
        end
      end
      OP_SUSTAIN: begin
        if (ent.chan == ch_q) begin
          if (ch_q == DRUM_CHANNEL) begin
            pr_stop = pr_act;
          end else begin
            pr_ent.level = ent.level >> 1;
            pr_ent.rel   = ent.pos + RELEASE_TICKS;
            pr_wr        = 1'b1;
            pr_emit      = pr_act;
          end
        end
      end
      OP_ALL_OFF: begin
        pr_stop = pr_act;
      end
      OP_PROGRAM: begin
        pr_stop = pr_act && ent.chan == ch_q;
      end
      OP_TICK: begin
        if (pr_act) begin
          pr_ent.pos = ent.pos + 16'd1;
          pr_wr      = 1'b1;
          if (ent.chan == DRUM_CHANNEL) begin
            pr_stop = ent.pos > DRUM_TIMEOUT;
          end else if (ent.pos == DECAY_POS) begin
            pr_ent.level = ent.level - (ent.level >> 2);
            pr_emit      = 1'b1;
          end else if (ent.pos != 16'd0 && ent.pos == ent.rel) begin
            pr_stop = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  logic emit_v;
  res_t emit_r;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    ch_d       = ch_q;
    d1_d       = d1_q;
    d2_d       = d2_q;
    word_d     = word_q;
    pos_d      = pos_q;
    len_d      = len_q;
    sysex_d    = sysex_q;
    sustain_d  = sustain_q;
    vol_d      = vol_q;
    mask_d     = mask_q;
    vld_d      = vld_q;
    rd_cnt_d   = rd_cnt_q;
    p_vld_d    = 1'b0;
    p_idx_d    = p_idx_q;
    hit_d      = hit_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_stb_d  = 1'b0;
    out_d      = out_q;
    out_last_d = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = p_idx_q;
    ram_wdata  = pr_ent;
    emit_v     = 1'b0;
    emit_r     = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          rd_cnt_d = '0;
          hit_d    = 1'b0;
          case (req_type_i)
            REQ_MIDI: begin
              word_d  = word_n;
              pos_d   = pos_n;
              len_d   = len_n;
              sysex_d = sx_n;
              if (apply) begin
                ch_d = mch;
                d1_d = md1;
                d2_d = md2;
                case (word_n[7:4])
                  ST_NOTE_ON: begin
                    if (md2 != 7'd0) begin
                      state_d = S_NOTE_ON;
                    end else if (!sustain_q[mch]) begin
                      op_d    = OP_NOTE_OFF;
                      state_d = S_WALK;
                    end
                  end
                  ST_NOTE_OFF: begin
                    if (!sustain_q[mch]) begin
                      op_d    = OP_NOTE_OFF;
                      state_d = S_WALK;
                    end
                  end
                  ST_CTRL: begin
                    if (md1 == CC_VOLUME) begin
                      vol_d[mch] = md2;
                      op_d       = OP_VOLUME;
                      state_d    = S_WALK;
                    end else if (md1 == CC_SUSTAIN) begin
                      if (md2[6]) begin
                        sustain_d[mch] = 1'b1;
                      end else begin
                        sustain_d[mch] = 1'b0;
                        op_d           = OP_SUSTAIN;
                        state_d        = S_WALK;
                      end
                    end else if (md1 == CC_ALL_OFF || md1 == CC_NOTES_OFF) begin
                      op_d    = OP_ALL_OFF;
                      state_d = S_WALK;
                    end else if (md1 == CC_RESET) begin
                      for (int c = 0; c < CHANNEL_COUNT; c++) begin
                        vol_d[c] = 7'd0;
                      end
                    end
                  end
                  ST_PROGRAM: begin
                    op_d    = OP_PROGRAM;
                    state_d = S_WALK;
                  end
                  default: begin
                  end
                endcase
              end
            end
            REQ_TICK: begin
              op_d    = OP_TICK;
              state_d = S_WALK;
            end
            REQ_ALL_OFF: begin
              op_d    = OP_ALL_OFF;
              state_d = S_WALK;
            end
            default: begin
            end
          endcase
        end
      end

      S_NOTE_ON: begin
        if (free_found) begin
          ram_we          = 1'b1;
          ram_waddr       = free_idx;
          ram_wdata.chan  = ch_q;
          ram_wdata.note  = d1_q;
          ram_wdata.level = on_level;
          ram_wdata.base  = d2_q;
          ram_wdata.pos   = 16'd0;
          ram_wdata.rel   = 16'd0;
          vld_d[free_idx]  = 1'b1;
          mask_d[free_idx] = 1'b1;
          emit_v        = 1'b1;
          emit_r.slot   = 5'(free_idx);
          emit_r.active = 1'b1;
          emit_r.chan   = ch_q;
          emit_r.note   = d1_q;
          emit_r.level  = on_level;
          state_d       = S_FLUSH;
        end else if (!sustain_q[ch_q]) begin
          op_d    = OP_NOTE_OFF;
          state_d = S_WALK;
        end else begin
          state_d = S_FLUSH;
        end
      end

      S_WALK: begin
        if (pr_live) begin
          if (pr_wr) begin
            ram_we          = 1'b1;
            vld_d[p_idx_q]  = 1'b1;
          end
          if (pr_stop) begin
            mask_d[p_idx_q] = 1'b0;
          end
          if (pr_hit) begin
            hit_d = 1'b1;
          end
          emit_v        = pr_emit || pr_stop;
          emit_r.slot   = 5'(p_idx_q);
          emit_r.active = !pr_stop;
          emit_r.chan   = ent.chan;
          emit_r.note   = ent.note;
          emit_r.level  = pr_stop ? 7'd0 : pr_ent.level;
        end
        // next read overlaps the current write; addresses always differ
        if (rd_cnt_q < CNT_W'(VOICE_COUNT) && !hit_q && !(pr_live && pr_hit)) begin
          ram_re   = 1'b1;
          p_vld_d  = 1'b1;
          p_idx_d  = rd_cnt_q[SLOT_W-1:0];
          rd_cnt_d = rd_cnt_q + CNT_W'(1);
        end else begin
          state_d = S_FLUSH;
        end
      end

      S_FLUSH: begin
        out_stb_d  = pend_vld_q;
        out_d      = pend_q;
        out_last_d = 1'b1;
        pend_vld_d = 1'b0;
        if (op_q == OP_ALL_OFF) begin
          vld_d     = '0;
          mask_d    = '0;
          sustain_d = '0;
        end
        op_d    = OP_NONE;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // one result held back so the last one can be flagged
    if (emit_v) begin
      if (pend_vld_q) begin
        out_stb_d  = 1'b1;
        out_d      = pend_q;
        out_last_d = 1'b0;
      end
      pend_d     = emit_r;
      pend_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= OP_NONE;
      word_q     <= '0;
      pos_q      <= '0;
      len_q      <= '0;
      sysex_q    <= 1'b0;
      sustain_q  <= '0;
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        vol_q[c] <= 7'd0;
      end
      mask_q     <= '0;
      vld_q      <= '0;
      rd_cnt_q   <= '0;
      p_vld_q    <= 1'b0;
      hit_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      out_stb_q  <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      word_q     <= word_d;
      pos_q      <= pos_d;
      len_q      <= len_d;
      sysex_q    <= sysex_d;
      sustain_q  <= sustain_d;
      vol_q      <= vol_d;
      mask_q     <= mask_d;
      vld_q      <= vld_d;
      rd_cnt_q   <= rd_cnt_d;
      p_vld_q    <= p_vld_d;
      hit_q      <= hit_d;
      pend_vld_q <= pend_vld_d;
      out_stb_q  <= out_stb_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q    <= ch_d;
    d1_q    <= d1_d;
    d2_q    <= d2_d;
    p_idx_q <= p_idx_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
  end

  assign result_strobe_o = out_stb_q;
  assign voice_slot_o    = out_q.slot;
  assign voice_active_o  = out_q.active;
  assign voice_channel_o = out_q.chan;
  assign voice_note_o    = out_q.note;
  assign voice_level_o   = out_q.level;
  assign last_change_o   = out_last_q;

`ifndef SYNTH
  a_no_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q == S_IDLE && pend_vld_q))
    else $error("result left pending while idle");

  a_stage_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_vld_q |-> state_q == S_WALK)
    else $error("voice stage valid outside a walk");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_cnt_q <= CNT_W'(VOICE_COUNT))
    else $error("walk counter out of range");

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && last_change_o) |=> !result_strobe_o)
    else $error("result straight after last of a transaction");

  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_v && !emit_r.active) |=> !mask_q[$past(p_idx_q)])
    else $error("stopped voice still marked active");
`endif

endmodule

// ===== src/mpva_ram.sv =====
module mpva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import mpva_pkg::*;

  localparam logic [3:0] ST_BEND = 4'hE;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic [1:0] REQ_UNDEF = 2'd3;

  typedef struct {
    logic [1:0] req;
    logic [7:0] data;
    int         gap_pct;
    bit         drain;
  } stim_t;

  typedef struct {
    logic [4:0] slot;
    logic       active;
    logic [3:0] chan;
    logic [6:0] note;
    logic [6:0] level;
    logic       last;
  } change_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] req_type_i = REQ_MIDI;
  logic [7:0] midi_byte_i = 8'h00;
  logic       result_strobe_o;
  logic [4:0] voice_slot_o;
  logic       voice_active_o;
  logic [3:0] voice_channel_o;
  logic [6:0] voice_note_o;
  logic [6:0] voice_level_o;
  logic       last_change_o;

  midi_parser_voice_allocator dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // voice table copy
  logic [3:0]  vc_chan  [VOICE_COUNT];
  logic [6:0]  vc_note  [VOICE_COUNT];
  logic [6:0]  vc_level [VOICE_COUNT];
  logic [6:0]  vc_base  [VOICE_COUNT];
  logic [15:0] vc_pos   [VOICE_COUNT];
  logic [15:0] vc_rel   [VOICE_COUNT];
  logic [31:0] sounding;
  logic [15:0] sustained;
  logic [6:0]  chan_vol   [CHANNEL_COUNT];
  logic [6:0]  ch_program [CHANNEL_COUNT];
  logic [23:0] msg_word;
  logic [2:0]  msg_pos;
  logic [1:0]  msg_len;
  logic        skipping_sysex;

  stim_t   midi_backlog[$];
  change_t pending_changes[$];
  int      mismatches = 0;
  int      gap_pct = 0;
  int      idle_cycles = 0;

  function automatic void clear_voices();
    for (int i = 0; i < VOICE_COUNT; i++) begin
      vc_chan[i] = '0; vc_note[i] = '0; vc_level[i] = '0;
      vc_base[i] = '0; vc_pos[i] = '0; vc_rel[i] = '0;
    end
    sounding = '0;
    sustained = '0;
  endfunction

  function automatic void post_change(int i, bit act, logic [6:0] lvl);
    change_t c;
    c.slot = 5'(i);
    c.active = act;
    c.chan = vc_chan[i];
    c.note = vc_note[i];
    c.level = act ? lvl : 7'd0;
    c.last = 1'b0;
    pending_changes.push_back(c);
  endfunction

  function automatic void stop_slot(int i);
    sounding[i] = 1'b0;
    post_change(i, 1'b0, 7'd0);
  endfunction

  function automatic void release_slot(int i);
    vc_level[i] = vc_level[i] >> 1;
    vc_rel[i] = vc_pos[i] + RELEASE_TICKS;
  endfunction

  function automatic void silence_all();
    for (int i = 0; i < VOICE_COUNT; i++)
      if (sounding[i]) stop_slot(i);
    clear_voices();
  endfunction

  function automatic void key_release(logic [3:0] ch, logic [6:0] nt);
    if (sustained[ch]) return;
    for (int i = 0; i < VOICE_COUNT; i++) begin
      if (sounding[i] && vc_chan[i] == ch && vc_note[i] == nt) begin
        if (ch == DRUM_CHANNEL) stop_slot(i);
        else begin
          release_slot(i);
          post_change(i, 1'b1, vc_level[i]);
        end
        return;
      end
    end
  endfunction

  function automatic void run_message();
    logic [3:0] st;
    logic [3:0] ch;
    logic [6:0] d1;
    logic [6:0] d2;
    logic [13:0] prod;
    st = msg_word[7:4];
    ch = msg_word[3:0];
    d1 = msg_word[14:8];
    d2 = msg_word[22:16];
    case (st)
      ST_NOTE_ON: begin
        if (d2 != 0) begin
          for (int i = 0; i < VOICE_COUNT; i++) begin
            if (!sounding[i]) begin
              vc_chan[i] = ch; vc_note[i] = d1; vc_base[i] = d2;
              vc_pos[i] = '0; vc_rel[i] = '0;
              prod = chan_vol[ch] * d2;
              vc_level[i] = (chan_vol[ch] != 0) ? prod[13:7] : d2;
              sounding[i] = 1'b1;
              post_change(i, 1'b1, vc_level[i]);
              return;
            end
          end
        end
        key_release(ch, d1);
      end
      ST_NOTE_OFF: key_release(ch, d1);
      ST_CTRL: begin
        if (d1 == CC_VOLUME) begin
          chan_vol[ch] = d2;
          for (int i = 0; i < VOICE_COUNT; i++) begin
            if (vc_chan[i] != ch) continue;
            prod = d2 * vc_base[i];
            vc_level[i] = prod[13:7];
            if (sounding[i]) post_change(i, 1'b1, vc_level[i]);
          end
        end else if (d1 == CC_SUSTAIN) begin
          if (d2[6]) sustained[ch] = 1'b1;
          else begin
            sustained[ch] = 1'b0;
            for (int i = 0; i < VOICE_COUNT; i++) begin
              if (vc_chan[i] != ch) continue;
              if (ch == DRUM_CHANNEL) begin
                if (sounding[i]) stop_slot(i);
              end else begin
                release_slot(i);
                if (sounding[i]) post_change(i, 1'b1, vc_level[i]);
              end
            end
          end
        end else if (d1 == CC_ALL_OFF || d1 == CC_NOTES_OFF) begin
          silence_all();
        end else if (d1 == CC_RESET) begin
          for (int c = 0; c < CHANNEL_COUNT; c++) begin
            chan_vol[c] = '0; ch_program[c] = '0;
          end
        end
      end
      ST_PROGRAM: begin
        ch_program[ch] = d1;
        for (int i = 0; i < VOICE_COUNT; i++)
          if (vc_chan[i] == ch && sounding[i]) stop_slot(i);
      end
      default: ;
    endcase
  endfunction

  function automatic void take_byte(logic [7:0] b);
    if (b[7] && !(b == SYSEX_END && skipping_sysex)) begin
      msg_pos = '0;
      msg_len = MSG_LEN[b[6:4]];
      msg_word = '0;
      if (b == SYSEX_START) skipping_sysex = 1'b1;
    end
    if (skipping_sysex) begin
      if (b == SYSEX_END) skipping_sysex = 1'b0;
      return;
    end
    if (msg_len == 0) return;
    if (msg_pos < 3) msg_word[msg_pos*8 +: 8] = b;
    if (msg_pos < 4) msg_pos = msg_pos + 3'd1;
    if (msg_pos == {1'b0, msg_len}) run_message();
  endfunction

  function automatic void age_voices();
    logic [15:0] p;
    for (int i = 0; i < VOICE_COUNT; i++) begin
      if (!sounding[i]) continue;
      p = vc_pos[i];
      vc_pos[i] = p + 16'd1;
      if (vc_chan[i] == DRUM_CHANNEL) begin
        if (p > DRUM_TIMEOUT) stop_slot(i);
      end else if (p == DECAY_POS) begin
        vc_level[i] = vc_level[i] - (vc_level[i] >> 2);
        post_change(i, 1'b1, vc_level[i]);
      end else if (p != 0 && p == vc_rel[i]) begin
        stop_slot(i);
      end
    end
  endfunction

  function automatic void predict_voice_changes(logic [1:0] req, logic [7:0] b);
    int before_n;
    before_n = pending_changes.size();
    case (req)
      REQ_MIDI:    take_byte(b);
      REQ_TICK:    age_voices();
      REQ_ALL_OFF: silence_all();
      default: ;
    endcase
    if (pending_changes.size() > before_n)
      pending_changes[pending_changes.size()-1].last = 1'b1;
  endfunction

  // stimulus helpers
  function automatic void add(logic [1:0] req, logic [7:0] b, bit drain = 1'b0);
    stim_t s;
    s.req = req; s.data = b; s.gap_pct = gap_pct; s.drain = drain;
    midi_backlog.push_back(s);
  endfunction

  function automatic void add_msg(logic [3:0] st, logic [3:0] ch, logic [6:0] d1,
                                  logic [6:0] d2);
    add(REQ_MIDI, {st, ch});
    add(REQ_MIDI, {1'b0, d1});
    if (st != ST_PROGRAM) add(REQ_MIDI, {1'b0, d2});
  endfunction

  function automatic logic [3:0] pick_chan();
    case ($urandom_range(3))
      0: return 4'd0;
      1: return DRUM_CHANNEL;
      2: return 4'd1;
      default: return 4'($urandom_range(15));
    endcase
  endfunction

  function automatic void add_random();
    logic [3:0] ch;
    logic [6:0] nt;
    ch = pick_chan();
    nt = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(62, 65));
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5: add_msg(ST_NOTE_ON, ch, nt, 7'($urandom_range(127)));
      6, 7:  add_msg(ST_NOTE_OFF, ch, nt, 7'($urandom_range(127)));
      8:     add_msg(ST_CTRL, ch, CC_VOLUME, 7'($urandom_range(127)));
      9:     add_msg(ST_CTRL, ch, CC_SUSTAIN, 7'($urandom_range(127)));
      10: begin
        case ($urandom_range(3))
          0: add_msg(ST_CTRL, ch, CC_ALL_OFF, 7'($urandom_range(127)));
          1: add_msg(ST_CTRL, ch, CC_NOTES_OFF, 7'($urandom_range(127)));
          2: add_msg(ST_CTRL, ch, CC_RESET, 7'($urandom_range(127)));
          default: add_msg(ST_CTRL, ch, 7'($urandom_range(127)), 7'($urandom_range(127)));
        endcase
      end
      11:     add_msg(ST_PROGRAM, ch, 7'($urandom_range(127)), 7'd0);
      12:     add_msg(ST_BEND, ch, 7'($urandom_range(127)), 7'($urandom_range(127)));
      13, 14: repeat ($urandom_range(1, 4)) add(REQ_TICK, 8'($urandom_range(255)));
      15: begin
        add(REQ_MIDI, SYSEX_START);
        repeat ($urandom_range(0, 3)) add(REQ_MIDI, 8'($urandom_range(255)));
        add(REQ_MIDI, SYSEX_END);
      end
      16: if ($urandom_range(3) == 0) add(REQ_ALL_OFF, 8'($urandom_range(255)));
      17: add(REQ_UNDEF, 8'($urandom_range(255)));
      default: add(REQ_MIDI, 8'($urandom_range(255)));
    endcase
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_type_i <= REQ_MIDI;
      midi_byte_i <= 8'h00;
    end else begin
      if (start && !busy) predict_voice_changes(req_type_i, midi_byte_i);
      if (!(start && busy)) begin
        if (midi_backlog.size() > 0 && !(midi_backlog[0].drain && pending_changes.size() > 0)
            && $urandom_range(99) >= midi_backlog[0].gap_pct) begin
          req_type_i <= midi_backlog[0].req;
          midi_byte_i <= midi_backlog[0].data;
          start <= 1'b1;
          void'(midi_backlog.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    change_t e;
    if (rst_ni && result_strobe_o) begin
      if (pending_changes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected voice change: slot %0d active %0d", voice_slot_o, voice_active_o);
      end else begin
        e = pending_changes.pop_front();
        if (voice_slot_o !== e.slot || voice_active_o !== e.active ||
            voice_channel_o !== e.chan || voice_note_o !== e.note ||
            voice_level_o !== e.level || last_change_o !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp slot %0d act %0d ch %0d note %0d lvl %0d last %0d",
                      " / got %0d %0d %0d %0d %0d %0d"},
                     e.slot, e.active, e.chan, e.note, e.level, e.last,
                     voice_slot_o, voice_active_o, voice_channel_o, voice_note_o,
                     voice_level_o, last_change_o);
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_strobe_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    clear_voices();
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      chan_vol[c] = '0; ch_program[c] = '0;
    end
    msg_word = '0; msg_pos = '0; msg_len = '0; skipping_sysex = 1'b0;

    // directed
    gap_pct = 0;
    add_msg(ST_NOTE_ON, 4'd0, 7'd0, 7'd127);
    add_msg(ST_CTRL, 4'd0, CC_VOLUME, 7'd127);
    add_msg(ST_NOTE_ON, 4'd0, 7'd127, 7'd0);
    add_msg(ST_NOTE_OFF, 4'd0, 7'd0, 7'd0);
    add_msg(ST_NOTE_ON, DRUM_CHANNEL, 7'd36, 7'd1);
    add_msg(ST_NOTE_OFF, DRUM_CHANNEL, 7'd36, 7'd0);
    add(REQ_MIDI, 8'h7F);                // data byte with no message open
    add(REQ_MIDI, SYSEX_START);
    add(REQ_MIDI, {ST_NOTE_ON, 4'd0});   // swallowed by sysex
    add(REQ_MIDI, SYSEX_END);
    add(REQ_MIDI, 8'hFF);                // one-byte system message
    add(REQ_UNDEF, 8'hFF);
    add(REQ_ALL_OFF, 8'h00, 1'b1);

    // sustain, release, program, reset and ageing
    add_msg(ST_CTRL, 4'd1, CC_SUSTAIN, 7'h7F);
    add_msg(ST_NOTE_ON, 4'd1, 7'd60, 7'd100);
    add_msg(ST_NOTE_ON, 4'd2, 7'd61, 7'd90);
    add_msg(ST_NOTE_ON, 4'd3, 7'd62, 7'd80);
    add_msg(ST_NOTE_ON, DRUM_CHANNEL, 7'd38, 7'd70);
    add_msg(ST_NOTE_OFF, 4'd1, 7'd60, 7'd0);
    add_msg(ST_NOTE_OFF, 4'd2, 7'd61, 7'd0);
    repeat (3) add(REQ_TICK, 8'h00);
    add_msg(ST_CTRL, 4'd1, CC_SUSTAIN, 7'h00);
    add_msg(ST_CTRL, DRUM_CHANNEL, CC_SUSTAIN, 7'h00);
    repeat (4) add(REQ_TICK, 8'h00);
    add_msg(ST_PROGRAM, 4'd3, 7'd5, 7'd0);
    add_msg(ST_CTRL, 4'd0, CC_RESET, 7'd0);
    add_msg(ST_CTRL, 4'd0, CC_ALL_OFF, 7'd0);

    // random phases: none, sender gaps, none again, mixed
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = (ph == 1) ? 50 : (ph == 3) ? 34 : 0;
      repeat (20) add_random();
      add(REQ_TICK, 8'h00, 1'b1);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (midi_backlog.size() == 0 && !start);
    wait (pending_changes.size() == 0);
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && pending_changes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/mpva_pkg.sv
src/mpva_ram.sv
src/midi_parser_voice_allocator.sv
tb/testbench.sv
